// File: rtl/bcx_pkg.sv
// Shared types, constants and the popcount function for the binary 3x3 conv block.
// No dependencies; every other file imports this package.
package bcx_pkg;

    // Fixed field widths
    localparam int WORD_BITS = 32;
    localparam int TAPS      = 9;
    localparam int TAP_W     = 4;
    localparam int CH_W      = 5;
    localparam int POS_W     = 5;
    localparam int SUM_W     = 9;
    localparam int PC_W      = $clog2(WORD_BITS + 1);
    localparam int MAX_SUM   = TAPS * WORD_BITS;

    // Defaults for the top-level parameters
    localparam int DEF_OUT_CHANNELS = 32;
    localparam int DEF_IMG_ROWS     = 32;
    localparam int DEF_IMG_COLS     = 32;

    // Request kinds
    typedef enum logic {
        FUNC_WEIGHT = 1'b0,
        FUNC_PIXEL  = 1'b1
    } t_func;

    // Ones count of a nibble
    localparam logic [2:0] NIBBLE_ONES [16] = '{
        3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
        3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
    };

    // One tap step travelling from the sequencer to the accumulate unit
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last_tap;
        logic              last_ch;
        logic [TAP_W-1:0]  tap;
        logic [CH_W-1:0]   channel;
    } t_acc_ctl;

    // Finished channel sum from the accumulate unit
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CH_W-1:0]   channel;
        logic [SUM_W-1:0]  sum;
    } t_acc_res;

    // Count of set bits, one nibble lookup per step
    function automatic logic [PC_W-1:0] popcount_word(input logic [WORD_BITS-1:0] w);
        logic [PC_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS / 4; i++) begin
            n = n + PC_W'(NIBBLE_ONES[w[4*i +: 4]]);
        end
        return n;
    endfunction

endpackage

// File: rtl/bcx_if.sv
// Valid/ready channel interfaces for requests and channel sums.
// Depends on bcx_pkg for the field widths.
interface bcx_in_if
    import bcx_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [CH_W-1:0]       weight_channel;
    logic [TAP_W-1:0]      weight_tap;
    logic [WORD_BITS-1:0]  data_word;

    modport source (output valid, func, weight_channel, weight_tap, data_word, input ready);
    modport sink   (input valid, func, weight_channel, weight_tap, data_word, output ready);
endinterface

interface bcx_out_if
    import bcx_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  out_row;
    logic [POS_W-1:0]  out_col;
    logic [CH_W-1:0]   out_channel;
    logic [SUM_W-1:0]  match_sum;
    logic              last;

    modport source (output valid, out_row, out_col, out_channel, match_sum, last, input ready);
    modport sink   (input valid, out_row, out_col, out_channel, match_sum, last, output ready);
endinterface

// File: rtl/bcx_wmem.sv
// Weight memory: OUT_CHANNELS x 9 packed words, one write and one registered read per cycle.
// Depends on bcx_pkg.
module bcx_wmem
    import bcx_pkg::*;
#(
    parameter int OUT_CHANNELS = DEF_OUT_CHANNELS
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [CH_W-1:0]                        i_wr_channel,
    input  logic [TAP_W-1:0]                       i_wr_tap,
    input  logic [WORD_BITS-1:0]                   i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [$clog2(OUT_CHANNELS*TAPS)-1:0]   i_rd_addr,
    output logic [WORD_BITS-1:0]                   o_rd_data
);
    localparam int DEPTH = OUT_CHANNELS * TAPS;
    localparam int AW    = $clog2(DEPTH);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 wr_ok;
    logic [AW-1:0]        wr_addr;

    // Out-of-range taps and channels are dropped
    assign wr_ok   = i_wr_en && (int'(i_wr_tap) < TAPS) && (int'(i_wr_channel) < OUT_CHANNELS);
    assign wr_addr = AW'(int'(i_wr_channel) * TAPS + int'(i_wr_tap));

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: rtl/bcx_window.sv
// Pixel position counters, two line memories and the 3x2 window registers.
// Presents the full 3x3 window for the incoming pixel. Depends on bcx_pkg.
module bcx_window
    import bcx_pkg::*;
#(
    parameter int IMG_ROWS = DEF_IMG_ROWS,
    parameter int IMG_COLS = DEF_IMG_COLS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_pix_en,
    input  logic [WORD_BITS-1:0]              i_pix_word,
    output logic [TAPS-1:0][WORD_BITS-1:0]    o_win,
    output logic                              o_emit,
    output logic [POS_W-1:0]                  o_row,
    output logic [POS_W-1:0]                  o_col,
    output logic                              o_line_ok
);
    localparam int ROW_W = $clog2(IMG_ROWS);
    localparam int COL_W = $clog2(IMG_COLS);

    logic [ROW_W-1:0]     r_row;
    logic [COL_W-1:0]     r_col;
    logic                 r_line_ok;
    logic [WORD_BITS-1:0] line0 [IMG_COLS];
    logic [WORD_BITS-1:0] line1 [IMG_COLS];
    logic [WORD_BITS-1:0] r_line0_q;
    logic [WORD_BITS-1:0] r_line1_q;
    logic [WORD_BITS-1:0] r_wr [3][2];

    // Position of the next pixel; line read data is good once the registered read has caught up with a move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_line_ok <= 1'b0;
        end else begin
            r_line_ok <= !i_pix_en;
            if (i_pix_en) begin
                if (r_col == COL_W'(IMG_COLS - 1)) begin
                    r_col <= '0;
                    r_row <= (r_row == ROW_W'(IMG_ROWS - 1)) ? '0 : ROW_W'(r_row + 1'b1);
                end else begin
                    r_col <= COL_W'(r_col + 1'b1);
                end
            end
        end
    end

    // Line memories: shift the column up one row, registered read at the current column
    always_ff @(posedge i_clk) begin
        if (i_pix_en) begin
            line0[r_col] <= r_line1_q;
            line1[r_col] <= i_pix_word;
        end
        r_line0_q <= line0[r_col];
        r_line1_q <= line1[r_col];
    end

    // Window registers shift left by one column
    always_ff @(posedge i_clk) begin
        if (i_pix_en) begin
            for (int k = 0; k < 3; k++) begin
                r_wr[k][0] <= r_wr[k][1];
            end
            r_wr[0][1] <= r_line0_q;
            r_wr[1][1] <= r_line1_q;
            r_wr[2][1] <= i_pix_word;
        end
    end

    // Tap order is row*3 + col
    always_comb begin
        o_win[0] = r_wr[0][0];
        o_win[1] = r_wr[0][1];
        o_win[2] = r_line0_q;
        o_win[3] = r_wr[1][0];
        o_win[4] = r_wr[1][1];
        o_win[5] = r_line1_q;
        o_win[6] = r_wr[2][0];
        o_win[7] = r_wr[2][1];
        o_win[8] = i_pix_word;
    end

    assign o_emit    = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
    assign o_row     = POS_W'(ROW_W'(r_row - 1'b1));
    assign o_col     = POS_W'(COL_W'(r_col - 1'b1));
    assign o_line_ok = r_line_ok;
endmodule

// File: rtl/bcx_acc.sv
// Shared XNOR/popcount accumulate unit: one tap per cycle against the latched window, unless stalled.
// Depends on bcx_pkg.
module bcx_acc
    import bcx_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_load,
    input  logic [TAPS-1:0][WORD_BITS-1:0]    i_win,
    input  t_acc_ctl                          i_ctl,
    input  logic [WORD_BITS-1:0]              i_wdata,
    output t_acc_res                          o_res,
    output logic                              o_busy
);
    logic [WORD_BITS-1:0] r_win [TAPS];
    t_acc_ctl             r_ctl;
    logic [SUM_W-1:0]     r_acc;
    logic [WORD_BITS-1:0] match;
    logic [PC_W-1:0]      pc;
    logic [SUM_W-1:0]     sum;

    // Window captured when a pixel completes an interior position
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int t = 0; t < TAPS; t++) begin
                r_win[t] <= i_win[t];
            end
        end
    end

    // Control travels alongside the registered weight read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // Matching bits of this tap added to the running channel sum
    assign match = ~(r_win[r_ctl.tap] ^ i_wdata);
    assign pc    = popcount_word(match);
    assign sum   = (r_ctl.first ? '0 : r_acc) + SUM_W'(pc);

    always_ff @(posedge i_clk) begin
        if (i_en && r_ctl.valid) begin
            r_acc <= sum;
        end
    end

    assign o_res.valid   = r_ctl.valid && r_ctl.last_tap;
    assign o_res.last    = r_ctl.last_ch;
    assign o_res.channel = r_ctl.channel;
    assign o_res.sum     = sum;
    assign o_busy        = r_ctl.valid;
endmodule

// File: rtl/binary_conv3x3_xnor_popcount_top.sv
// Weight request: taken while idle. Pixel without an interior position: ready again once the line reads catch up.
// Interior pixel: the nine taps of each channel in turn give one sum per channel, channel 0 first;
// the single popcount-accumulate unit and the one weight memory read port take one tap per cycle
// while the output does not stall.
// Reset (synchronous, active low) clears position, sequencer and output valid; weight
// and line memories hold nothing defined until written, and there is no clearing pass.
module binary_conv3x3_xnor_popcount_top
    import bcx_pkg::*;
#(
    parameter int OUT_CHANNELS = DEF_OUT_CHANNELS,
    parameter int IMG_ROWS     = DEF_IMG_ROWS,
    parameter int IMG_COLS     = DEF_IMG_COLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcx_in_if.sink      i_in,
    bcx_out_if.source   o_out
);
    localparam int AW    = $clog2(OUT_CHANNELS * TAPS);
    localparam int CHC_W = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                        r_state, n_state;
    logic [CHC_W-1:0]              r_ch, n_ch;
    logic [TAP_W-1:0]              r_tap, n_tap;
    logic [AW-1:0]                 r_addr, n_addr;
    logic [POS_W-1:0]              r_pos_row, r_pos_col;
    logic                          r_out_valid;
    logic [POS_W-1:0]              r_out_row, r_out_col;
    logic [CH_W-1:0]               r_out_channel;
    logic [SUM_W-1:0]              r_out_sum;
    logic                          r_out_last;

    logic                          req_acc, pix_acc, wgt_acc, start, stall, out_load;
    logic                          last_tap, last_ch;
    logic [TAPS-1:0][WORD_BITS-1:0] win;
    logic                          emit, line_ok, busy;
    logic [POS_W-1:0]              win_row, win_col;
    logic [WORD_BITS-1:0]          wdata;
    t_acc_ctl                      issue;
    t_acc_res                      res;

    // Request handshake
    assign i_in.ready = (r_state == S_IDLE) && line_ok && !busy;
    assign req_acc    = i_in.valid && i_in.ready;
    assign pix_acc    = req_acc && (i_in.func == FUNC_PIXEL);
    assign wgt_acc    = req_acc && (i_in.func == FUNC_WEIGHT);
    assign start      = pix_acc && emit;

    // Whole pipeline holds while a finished sum waits downstream
    assign stall    = r_out_valid && !o_out.ready;
    assign out_load = !stall && res.valid;

    bcx_window #(
        .IMG_ROWS (IMG_ROWS),
        .IMG_COLS (IMG_COLS)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix_en   (pix_acc),
        .i_pix_word (i_in.data_word),
        .o_win      (win),
        .o_emit     (emit),
        .o_row      (win_row),
        .o_col      (win_col),
        .o_line_ok  (line_ok)
    );

    bcx_wmem #(
        .OUT_CHANNELS (OUT_CHANNELS)
    ) u_wmem (
        .i_clk        (i_clk),
        .i_wr_en      (wgt_acc),
        .i_wr_channel (i_in.weight_channel),
        .i_wr_tap     (i_in.weight_tap),
        .i_wr_data    (i_in.data_word),
        .i_rd_en      (!stall),
        .i_rd_addr    (r_addr),
        .o_rd_data    (wdata)
    );

    bcx_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (!stall),
        .i_load  (start),
        .i_win   (win),
        .i_ctl   (issue),
        .i_wdata (wdata),
        .o_res   (res),
        .o_busy  (busy)
    );

    // Tap issue: channel-major, tap-minor, so the weight address just counts up
    assign last_tap = (r_tap == TAP_W'(TAPS - 1));
    assign last_ch  = (r_ch == CHC_W'(OUT_CHANNELS - 1));

    always_comb begin
        issue.valid    = (r_state == S_RUN);
        issue.first    = (r_tap == '0);
        issue.last_tap = last_tap;
        issue.last_ch  = last_ch;
        issue.tap      = r_tap;
        issue.channel  = CH_W'(r_ch);
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        n_tap   = r_tap;
        n_addr  = r_addr;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_RUN;
                    n_ch    = '0;
                    n_tap   = '0;
                    n_addr  = '0;
                end
            end
            S_RUN: begin
                if (!stall) begin
                    n_addr = AW'(r_addr + 1'b1);
                    if (last_tap) begin
                        n_tap = '0;
                        n_ch  = CHC_W'(r_ch + 1'b1);
                        if (last_ch) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_tap = TAP_W'(r_tap + 1'b1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, counters, position latch and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_tap       <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_tap   <= n_tap;
            r_addr  <= n_addr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (start) begin
            r_pos_row <= win_row;
            r_pos_col <= win_col;
        end
        if (out_load) begin
            r_out_row     <= r_pos_row;
            r_out_col     <= r_pos_col;
            r_out_channel <= res.channel;
            r_out_sum     <= res.sum;
            r_out_last    <= res.last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_row     = r_out_row;
    assign o_out.out_col     = r_out_col;
    assign o_out.out_channel = r_out_channel;
    assign o_out.match_sum   = r_out_sum;
    assign o_out.last        = r_out_last;
endmodule

// File: rtl/bcx_checker.sv
// Port-level checks for the binary 3x3 conv top, attached by bind.
// Depends on bcx_pkg and binary_conv3x3_xnor_popcount_top.
module bcx_checker
    import bcx_pkg::*;
#(
    parameter int OUT_CHANNELS = DEF_OUT_CHANNELS
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [POS_W-1:0]  i_out_row,
    input logic [POS_W-1:0]  i_out_col,
    input logic [CH_W-1:0]   i_out_channel,
    input logic [SUM_W-1:0]  i_out_sum,
    input logic              i_out_last
);
    // A stalled sum stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sum)
            && $stable(i_out_channel) && $stable(i_out_last))
        else $error("output sum changed while stalled");

    // Sums fit nine full words and sit at interior positions
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_sum <= SUM_W'(MAX_SUM)) && (i_out_row != '0)
            && (i_out_col != '0))
        else $error("sum or position out of range");

    // Last marker only on the final channel
    a_last_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_channel == CH_W'(OUT_CHANNELS - 1))))
        else $error("last marker on wrong channel");

    // No new request while a position still has sums to come
    a_busy_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("request taken mid-position");
endmodule

bind binary_conv3x3_xnor_popcount_top bcx_checker #(
    .OUT_CHANNELS (OUT_CHANNELS)
) u_bcx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_row     (o_out.out_row),
    .i_out_col     (o_out.out_col),
    .i_out_channel (o_out.out_channel),
    .i_out_sum     (o_out.match_sum),
    .i_out_last    (o_out.last)
);
